[rtl/core/assert_macros.svh]
// Assertion macros shared by the run-length pixel decoder modules.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: expression does not hold");
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(name, clk, rstn, expr)
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/rlpd_pkg.sv]
// Types and constants of the run-length pixel decoder.
// No dependencies; imported by every module of the block.
package rlpd_pkg;

    localparam int MAX_BPP       = 4;
    localparam int PIX_CNT_BITS  = 24;
    localparam int CNT_W         = PIX_CNT_BITS + 1;
    localparam int PIX_W         = 8 * MAX_BPP;
    localparam int BPP_W         = 3;
    localparam int LEFT_W        = 8;
    localparam int POS_W         = $clog2(MAX_BPP);
    localparam int TDATA_OUT_W   = ((PIX_W + CNT_W + 7) / 8) * 8;
    localparam int ADDR_W        = 3;

    localparam logic [CNT_W-1:0]  PIX_CAP     = CNT_W'(1) << PIX_CNT_BITS;
    localparam logic [BPP_W-1:0]  BPP_RESET   = BPP_W'(MAX_BPP);
    localparam logic [7:0]        RUN_FLAG    = 8'h80;
    localparam logic [6:0]        RUN_MASK    = 7'h7f;
    localparam logic [LEFT_W-1:0] RUN_BIAS    = LEFT_W'(3);
    localparam logic [LEFT_W-1:0] LIT_BIAS    = LEFT_W'(1);

    localparam logic REG_BPP    = 1'b0;
    localparam logic REG_PIXCNT = 1'b1;

    typedef enum logic [1:0] {
        PH_MARKER,
        PH_RUN,
        PH_LITERAL
    } phase_t;

    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [CNT_W-1:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [CNT_W-1:0] repeat_count;
        logic             zero_fill;
        logic             image_done;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

endpackage

[rtl/core/rlpd_cfg.sv]
// Configuration registers of the run-length pixel decoder, APB-style port.
// Depends on rlpd_pkg.
module rlpd_cfg
    import rlpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [BPP_W-1:0] bpp_reg;
    logic [CNT_W-1:0] pixcnt_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= BPP_RESET;
            pixcnt_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_BPP:    bpp_reg    <= pwdata[BPP_W-1:0];
                REG_PIXCNT: pixcnt_reg <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BPP:    prdata = 32'(bpp_reg);
            REG_PIXCNT: prdata = 32'(pixcnt_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.bpp         = bpp_reg;
    assign cfg.pixel_count = pixcnt_reg;

endmodule

[rtl/core/rlpd_decode.sv]
// Byte decoder: marker/pixel state and the results of one compressed byte.
// Depends on rlpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlpd_decode
    import rlpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output res_pair_t  res
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PIX_W-1:0]  asm_reg, asm_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0]  emitted_reg, emitted_next;
    logic              stopped_reg, stopped_next;

    logic [CNT_W-1:0]  limit;
    logic [BPP_W-1:0]  bpp_eff;
    logic              stop_now;
    logic [POS_W:0]    pos_inc;
    logic [PIX_W-1:0]  asm_or;
    logic              emit;
    logic [CNT_W-1:0]  remaining;
    logic [CNT_W-1:0]  cnt_raw;
    logic [CNT_W-1:0]  cnt_clip;
    logic [CNT_W-1:0]  emitted_upd;
    logic [CNT_W-1:0]  final_rem;
    logic [LEFT_W-1:0] left_dec;
    result_t           pix_res, fill_res, done_res;

    assign limit   = cfg.pixel_count[PIX_CNT_BITS] ? PIX_CAP : cfg.pixel_count;
    assign bpp_eff = (cfg.bpp == '0) ? BPP_W'(1)
                   : (cfg.bpp > BPP_W'(MAX_BPP)) ? BPP_W'(MAX_BPP) : cfg.bpp;

    assign stop_now  = stopped_reg | (emitted_reg >= limit);
    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign asm_or    = asm_reg | (PIX_W'(in_byte) << {pos_reg, 3'b000});
    assign emit      = !stop_now && (phase_reg != PH_MARKER)
                       && (BPP_W'(pos_inc) >= bpp_eff);
    assign remaining = limit - emitted_reg;
    assign cnt_raw   = (phase_reg == PH_RUN) ? CNT_W'(left_reg) : CNT_W'(1);
    assign cnt_clip  = (cnt_raw > remaining) ? remaining : cnt_raw;
    assign emitted_upd = emit ? emitted_reg + cnt_clip : emitted_reg;
    assign final_rem   = (limit > emitted_upd) ? limit - emitted_upd : '0;
    assign left_dec    = left_reg - LEFT_W'(1);

    // next state
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        asm_next     = asm_reg;
        left_next    = left_reg;
        emitted_next = emitted_upd;
        stopped_next = stopped_reg;
        if (stop_now) begin
            stopped_next = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_MARKER: begin
                    if ((in_byte & RUN_FLAG) != 8'h00) begin
                        left_next  = LEFT_W'(in_byte[6:0] & RUN_MASK) + RUN_BIAS;
                        phase_next = PH_RUN;
                    end else begin
                        left_next  = LEFT_W'(in_byte) + LIT_BIAS;
                        phase_next = PH_LITERAL;
                    end
                    pos_next = '0;
                    asm_next = '0;
                end
                PH_RUN, PH_LITERAL: begin
                    if (emit) begin
                        pos_next     = '0;
                        asm_next     = '0;
                        stopped_next = (emitted_upd >= limit);
                        if (phase_reg == PH_RUN) begin
                            left_next  = '0;
                            phase_next = PH_MARKER;
                        end else begin
                            left_next = left_dec;
                            if (left_dec == '0) begin
                                phase_next = PH_MARKER;
                            end
                        end
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                        asm_next = asm_or;
                    end
                end
                default: phase_next = PH_MARKER;
            endcase
        end
        if (last_byte) begin
            phase_next   = PH_MARKER;
            pos_next     = '0;
            asm_next     = '0;
            left_next    = '0;
            emitted_next = '0;
            stopped_next = 1'b0;
        end
    end

    // results
    always_comb begin
        pix_res.pixel_value   = asm_or;
        pix_res.repeat_count  = cnt_clip;
        pix_res.zero_fill     = 1'b0;
        pix_res.image_done    = last_byte && (final_rem == '0);
        fill_res.pixel_value  = '0;
        fill_res.repeat_count = final_rem;
        fill_res.zero_fill    = 1'b1;
        fill_res.image_done   = 1'b1;
        done_res.pixel_value  = '0;
        done_res.repeat_count = '0;
        done_res.zero_fill    = 1'b0;
        done_res.image_done   = 1'b1;
        res.r0 = pix_res;
        res.r1 = fill_res;
        if (emit) begin
            res.n = (last_byte && (final_rem != '0)) ? 2'd2 : 2'd1;
        end else if (last_byte) begin
            res.r0 = (final_rem != '0) ? fill_res : done_res;
            res.n  = 2'd1;
        end else begin
            res.n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MARKER;
            pos_reg     <= '0;
            asm_reg     <= '0;
            left_reg    <= '0;
            emitted_reg <= '0;
            stopped_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            asm_reg     <= asm_next;
            left_reg    <= left_next;
            emitted_reg <= emitted_next;
            stopped_reg <= stopped_next;
        end
    end

    `ASSERT_IMPLIES(a_pair_only_on_last, aclk, aresetn, res.n == 2'd2, last_byte)
    `ASSERT_IMPLIES(a_marker_pos_clear, aclk, aresetn, phase_reg == PH_MARKER, pos_reg == '0)
    `ASSERT_NEXT(a_last_clears, aclk, aresetn, in_accept && last_byte, emitted_reg == '0 && !stopped_reg)

endmodule

[rtl/core/rlpd_outbuf.sv]
// Two-entry result buffer: takes up to two results per transaction, hands out one.
// Depends on rlpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlpd_outbuf
    import rlpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  res_pair_t res,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;
    logic       wr;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid & out_ready;
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign wr        = in_valid & in_ready;
    assign out_res   = slot0_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (wr) begin
            cnt_next   = res.n;
            slot0_next = res.r0;
            slot1_next = res.r1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `ASSERT_IMPLIES(a_wr_when_drained, aclk, aresetn, wr, cnt_reg == 2'd0 || pop)
    `ASSERT_NEXT(a_pop_full, aclk, aresetn, cnt_reg == 2'd2 && pop, cnt_reg == 2'd1)

endmodule

[rtl/core/rl_pixel_run_decoder_unit.sv]
// Run-length pixel decoder: one compressed byte per transaction in, pixel runs out.
// Latency: a result is offered on m_ the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_tready is high; a final byte giving a pixel and a
// zero-fill result holds off the next byte, set by the single result port draining the buffer.
// Reset: synchronous, active low; clears decode state, bytes_per_pixel to 4.
// Depends on rlpd_pkg, rlpd_cfg, rlpd_decode, rlpd_outbuf.
module rl_pixel_run_decoder_unit
    import rlpd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] pixel_value, [56:32] repeat_count
    output logic                   m_tuser,   // zero_fill
    output logic                   m_tlast,   // image_done
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t      cfg;
    res_pair_t res;
    result_t   out_res;
    logic      in_accept;

    assign in_accept = s_tvalid & s_tready;

    rlpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlpd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .res       (res)
    );

    rlpd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = TDATA_OUT_W'({out_res.repeat_count, out_res.pixel_value});
    assign m_tuser = out_res.zero_fill;
    assign m_tlast = out_res.image_done;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for rl_pixel_run_decoder_unit: directed table, then random images.
// Holds its own decoder model; checks every m_ transaction against it or a directed row's expected result.
// Depends on rlpd_pkg and the decoder RTL.
module tb_top
    import rlpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1950;
    localparam int SETTLE       = 4;
    localparam int END_SETTLE   = 10;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;

    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        sel;
        logic [31:0] value;
        logic [7:0]  b;
        logic        last;
        logic        typed;
        result_t     want;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [7:0] in_byte
    logic                   s_tlast;    // last_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // [31:0] pixel_value, [56:32] repeat_count
    logic                   m_tuser;    // zero_fill
    logic                   m_tlast;    // image_done
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    rl_pixel_run_decoder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // decoder model state and register copies
    logic [BPP_W-1:0]  bpp_reg;
    logic [CNT_W-1:0]  pixcnt_reg;
    phase_t            dec_phase;
    int                byte_pos;
    logic [PIX_W-1:0]  assembly;
    logic [LEFT_W-1:0] run_left;
    logic [CNT_W-1:0]  emitted;
    logic              stopped;

    result_t   byte_runs[$];
    result_t   runs_due[$];
    stim_row_t directed[$];
    int        mismatches  = 0;
    int        bytes_sent  = 0;
    int        quiet       = 0;
    bit        calm        = 1'b0;
    bit        long_hold_req = 1'b0;

    function automatic result_t run_res(input logic [PIX_W-1:0] value,
                                        input logic [CNT_W-1:0] count,
                                        input logic fill, input logic done);
        result_t r;
        r.pixel_value  = value;
        r.repeat_count = count;
        r.zero_fill    = fill;
        r.image_done   = done;
        return r;
    endfunction

    function automatic stim_row_t wr(input logic sel, input logic [31:0] value);
        stim_row_t r;
        r = '{kind: ROW_WRITE, sel: sel, value: value, b: '0, last: 1'b0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t bt_want(input logic [7:0] b, input logic last,
                                          input logic typed, input result_t want);
        stim_row_t r;
        r = '{kind: ROW_BYTE, sel: 1'b0, value: '0, b: b, last: last,
              typed: typed, want: want};
        return r;
    endfunction

    function automatic stim_row_t bt(input logic [7:0] b, input logic last);
        return bt_want(b, last, 1'b0, '0);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_image();
        dec_phase = PH_MARKER;
        byte_pos  = 0;
        assembly  = '0;
        run_left  = '0;
        emitted   = '0;
        stopped   = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] count;
        int               bpp;
        result_t          px;
        logic             have_px;
        byte_runs.delete();
        limit   = (pixcnt_reg < PIX_CAP) ? pixcnt_reg : PIX_CAP;
        bpp     = (bpp_reg == 0) ? 1 : ((bpp_reg > MAX_BPP) ? MAX_BPP : int'(bpp_reg));
        have_px = 1'b0;
        px      = '0;
        if (emitted >= limit) stopped = 1'b1;
        if (!stopped) begin
            if (dec_phase == PH_MARKER) begin
                if ((b & RUN_FLAG) != 0) begin
                    run_left  = LEFT_W'(b[6:0] & RUN_MASK) + RUN_BIAS;
                    dec_phase = PH_RUN;
                end else begin
                    run_left  = LEFT_W'(b) + LIT_BIAS;
                    dec_phase = PH_LITERAL;
                end
                byte_pos = 0;
                assembly = '0;
            end else begin
                if (byte_pos < MAX_BPP) assembly |= PIX_W'(b) << (8 * byte_pos);
                byte_pos++;
                if (byte_pos >= bpp) begin
                    remaining = limit - emitted;
                    count = (dec_phase == PH_RUN) ? CNT_W'(run_left) : CNT_W'(1);
                    if (count > remaining) count = remaining;
                    px      = run_res(assembly, count, 1'b0, 1'b0);
                    have_px = 1'b1;
                    emitted = emitted + count;
                    byte_pos = 0;
                    assembly = '0;
                    if (dec_phase == PH_RUN) begin
                        run_left  = '0;
                        dec_phase = PH_MARKER;
                    end else begin
                        run_left = run_left - 1'b1;
                        if (run_left == 0) dec_phase = PH_MARKER;
                    end
                    if (emitted >= limit) stopped = 1'b1;
                end
            end
        end
        if (last) begin
            remaining = (limit > emitted) ? limit - emitted : '0;
            if (remaining != 0) begin
                if (have_px) byte_runs.push_back(px);
                byte_runs.push_back(run_res('0, remaining, 1'b1, 1'b1));
            end else if (have_px) begin
                px.image_done = 1'b1;
                byte_runs.push_back(px);
            end else begin
                byte_runs.push_back(run_res('0, '0, 1'b0, 1'b1));
            end
            clear_image();
        end else if (have_px) begin
            byte_runs.push_back(px);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic typed, input result_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last);
        if (typed) runs_due.push_back(want);
        else foreach (byte_runs[k]) runs_due.push_back(byte_runs[k]);
        bytes_sent++;
    endtask

    task automatic rest_sender(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_BPP) bpp_reg = value[BPP_W-1:0];
        else pixcnt_reg = value[CNT_W-1:0];
        @(posedge aclk);
    endtask

    task automatic send_random_image();
        logic [7:0]       img[$];
        logic [CNT_W-1:0] cnt;
        int               bpp;
        int               tgt;
        int               planned;
        int               mode;
        int               len;
        int               split_at;
        int               lim;
        if (!long_hold_req && $urandom_range(0, 2) == 0) begin
            drain_results();
            apb_write(REG_BPP, 32'($urandom_range(0, 7)));
            case ($urandom_range(0, 15))
                0: cnt = '0;
                1: cnt = '1;
                2: cnt = PIX_CAP;
                3: cnt = PIX_CAP - 1'b1;
                4: cnt = CNT_W'($urandom());
                default: cnt = CNT_W'($urandom_range(1, 60));
            endcase
            apb_write(REG_PIXCNT, 32'(cnt));
        end
        bpp  = (bpp_reg == 0) ? 1 : ((bpp_reg > MAX_BPP) ? MAX_BPP : int'(bpp_reg));
        tgt  = (pixcnt_reg > 60) ? $urandom_range(1, 60) : int'(pixcnt_reg);
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            repeat ($urandom_range(1, 24)) img.push_back(8'($urandom()));
        end else begin
            planned = 0;
            while (planned < tgt || (mode == 8 && planned < tgt + 8)) begin
                if ($urandom_range(0, 1) == 1) begin
                    len = ($urandom_range(0, 19) == 0) ? 127 : $urandom_range(0, 6);
                    img.push_back(RUN_FLAG | 8'(len));
                    repeat (bpp) img.push_back(8'($urandom()));
                    planned += len + 3;
                end else begin
                    len = ($urandom_range(0, 79) == 0) ? 127 : $urandom_range(0, 4);
                    img.push_back(8'(len));
                    repeat ((len + 1) * bpp) img.push_back(8'($urandom()));
                    planned += len + 1;
                end
            end
            // cut the stream short to leave a pixel or a run unfinished
            if (mode == 7 && img.size() > 1) begin
                len = $urandom_range(1, img.size() - 1);
                while (img.size() > len) void'(img.pop_back());
            end
        end
        if (img.size() == 0) img.push_back(8'($urandom()));
        split_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, img.size()) : -1;
        calm     = ($urandom_range(0, 4) == 0);
        foreach (img[k]) begin
            if (k == split_at) begin
                drain_results();
                lim = (pixcnt_reg > 60) ? 60 : int'(pixcnt_reg);
                apb_write(REG_PIXCNT, 32'($urandom_range(0, lim)));
            end
            push_byte(img[k], k == img.size() - 1, 1'b0, '0);
            rest_sender(calm ? 0 : pick_gap());
        end
    endtask

    initial begin : stimulus
        int random_target;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        bpp_reg    = BPP_RESET;
        pixcnt_reg = '0;
        clear_image();

        directed.push_back(bt_want(8'h00, 1'b1, 1'b1, run_res('0, '0, 1'b0, 1'b1)));
        directed.push_back(wr(REG_PIXCNT, 32'd5));
        directed.push_back(wr(REG_BPP, 32'd1));
        directed.push_back(bt(8'h82, 1'b0));
        directed.push_back(bt_want(8'hab, 1'b0, 1'b1, run_res(32'hab, 25'd5, 1'b0, 1'b0)));
        directed.push_back(bt_want(8'h55, 1'b1, 1'b1, run_res('0, '0, 1'b0, 1'b1)));
        directed.push_back(wr(REG_PIXCNT, 32'd10));
        directed.push_back(wr(REG_BPP, 32'd0));
        directed.push_back(bt(8'h00, 1'b0));
        directed.push_back(bt(8'h11, 1'b0));
        directed.push_back(bt(8'hff, 1'b0));
        directed.push_back(bt(8'hff, 1'b1));
        directed.push_back(wr(REG_BPP, 32'd7));
        directed.push_back(wr(REG_PIXCNT, 32'h01ff_ffff));
        directed.push_back(bt(8'h80, 1'b0));
        directed.push_back(bt(8'h01, 1'b0));
        directed.push_back(bt(8'h02, 1'b0));
        directed.push_back(bt(8'h03, 1'b0));
        directed.push_back(bt_want(8'h04, 1'b0, 1'b1,
                                   run_res(32'h0403_0201, 25'd3, 1'b0, 1'b0)));
        directed.push_back(bt(8'h7f, 1'b0));
        directed.push_back(bt(8'hff, 1'b0));
        directed.push_back(bt_want(8'h00, 1'b1, 1'b1,
                                   run_res('0, 25'd16777213, 1'b1, 1'b1)));
        directed.push_back(wr(REG_BPP, 32'd2));
        directed.push_back(wr(REG_PIXCNT, 32'd3));
        directed.push_back(bt(8'h81, 1'b0));
        directed.push_back(bt(8'h12, 1'b0));
        directed.push_back(bt_want(8'h34, 1'b0, 1'b1, run_res(32'h3412, 25'd3, 1'b0, 1'b0)));
        directed.push_back(bt_want(8'h99, 1'b1, 1'b1, run_res('0, '0, 1'b0, 1'b1)));
        directed.push_back(wr(REG_BPP, 32'd3));
        directed.push_back(wr(REG_PIXCNT, 32'd100));
        directed.push_back(bt(8'h00, 1'b0));
        directed.push_back(bt(8'hff, 1'b0));
        directed.push_back(bt(8'hff, 1'b0));
        directed.push_back(bt(8'hff, 1'b1));
        directed.push_back(wr(REG_BPP, 32'd1));
        directed.push_back(wr(REG_PIXCNT, 32'd2));
        directed.push_back(bt(8'h03, 1'b0));
        directed.push_back(bt(8'h10, 1'b0));
        directed.push_back(wr(REG_PIXCNT, 32'd1));
        directed.push_back(bt_want(8'h20, 1'b1, 1'b1, run_res('0, '0, 1'b0, 1'b1)));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                drain_results();
                apb_write(directed[i].sel, directed[i].value);
            end else begin
                push_byte(directed[i].b, directed[i].last, directed[i].typed,
                          directed[i].want);
                rest_sender(pick_gap());
            end
        end

        // hold the sink off while the source keeps offering bytes
        long_hold_req = 1'b1;
        random_target = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < random_target) send_random_image();

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatches == 0 && runs_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                stall = calm ? 0 : pick_gap();
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = run_res(m_tdata[31:0], m_tdata[56:32], m_tuser, m_tlast);
            if (runs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h count %0d fill %b done %b",
                             got.pixel_value, got.repeat_count, got.zero_fill,
                             got.image_done);
            end else begin
                want = runs_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected value %h count %0d fill %b done %b,",
                                  " got value %h count %0d fill %b done %b"},
                                 want.pixel_value, want.repeat_count, want.zero_fill,
                                 want.image_done, got.pixel_value, got.repeat_count,
                                 got.zero_fill, got.image_done);
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
